// ===== rtl/core/triangle_strip_fan_snake_assembler_macros.svh =====
// Assertion macros shared by the triangle assembler modules.
`ifndef TRIANGLE_STRIP_FAN_SNAKE_ASSEMBLER_MACROS_SVH
`define TRIANGLE_STRIP_FAN_SNAKE_ASSEMBLER_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define TSFSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tsfsa: same-cycle check failed");

// Next-cycle implication, off while reset is low.
`define TSFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tsfsa: next-cycle check failed");

`endif

// ===== rtl/core/tsfsa_pkg.sv =====
// Types, codes and constants of the triangle strip/fan/snake assembler.
package tsfsa_pkg;

    localparam int IDX_W            = 7;
    localparam int NUM_IDX          = 7;
    localparam int CNT_W            = 3;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // operation codes
    localparam logic [1:0] OP_STRIP       = 2'd0;
    localparam logic [1:0] OP_FAN         = 2'd1;
    localparam logic [1:0] OP_SNAKE_START = 2'd2;
    localparam logic [1:0] OP_SNAKE_BYTE  = 2'd3;

    // job modes
    localparam logic [1:0] MODE_STRIP = 2'd0;
    localparam logic [1:0] MODE_FAN   = 2'd1;
    localparam logic [1:0] MODE_SNAKE = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] command_high;
        logic [31:0] command_low;
        logic [7:0]  snake_byte;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_first;
        logic [IDX_W-1:0] vertex_second;
        logic [IDX_W-1:0] vertex_third;
        logic             last_of_run;
        logic             snake_ended;
    } t_out_word;

    // One queued job: 1 to 5 triangles out of up to seven indices.
    typedef struct packed {
        logic [1:0]                    mode;
        logic [NUM_IDX-1:0][IDX_W-1:0] idx;
        logic [CNT_W-1:0]              count;
        logic                          snake_ended;
    } t_job;

endpackage

// ===== rtl/core/triangle_strip_fan_snake_assembler.sv =====
// Path: a word's first triangle is registered in the job queue, then in the output register,
// with the job queue and back end idle; later triangles follow one per cycle while popped.
// Throughput: one input word per cycle while the job queue has room; one triangle per cycle
// out of the back end, a strip/fan word yielding 1 to 5 triangles and a snake word 1.
// Words that yield no triangle pass through the front end and never enter the job queue.
// Reset (i_rst_n low, synchronous): snake state, job queue and output valid flag clear.
module triangle_strip_fan_snake_assembler #(
    parameter int QUEUE_DEPTH = tsfsa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input side: queue-style push/full
    input  logic                 push,
    output logic                 full,
    input  tsfsa_pkg::t_in_word  i_in_word,
    // result side: queue-style empty/pop
    output logic                 empty,
    input  logic                 pop,
    output tsfsa_pkg::t_out_word o_out_word
);

    // front -> queue
    logic            job_push;
    tsfsa_pkg::t_job job_in;
    // queue -> back
    tsfsa_pkg::t_job job_head;
    logic            job_empty;
    logic            job_pop;
    logic            in_accept;

    // The front end only stalls on a full job queue; the output register
    // decouples the back end from the consumer.
    assign in_accept = push && !full;

    tsfsa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_word     (i_in_word),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    tsfsa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_head),
        .o_full  (full),
        .o_empty (job_empty)
    );

    // Back end walks the head job triangle by triangle and frees the queue
    // entry on the final one (last_of_run).
    tsfsa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!job_empty),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_word      (o_out_word)
    );

endmodule

// ===== rtl/core/tsfsa_front.sv =====
// Front end: accepts input words, keeps snake state, builds triangle jobs.
module tsfsa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  tsfsa_pkg::t_in_word i_word,
    output logic              o_job_push,
    output tsfsa_pkg::t_job   o_job
);

    logic       r_snake_active, n_snake_active;
    logic [7:0] r_snake_head, n_snake_head;
    logic [7:0] r_snake_left, n_snake_left;
    logic [7:0] r_snake_right, n_snake_right;

    logic [tsfsa_pkg::NUM_IDX-1:0][tsfsa_pkg::IDX_W-1:0] v;
    logic emit;

    assign v[0] = i_word.command_high[23:17];
    assign v[1] = i_word.command_high[15:9];
    assign v[2] = i_word.command_high[7:1];
    assign v[3] = i_word.command_low[31:25];
    assign v[4] = i_word.command_low[23:17];
    assign v[5] = i_word.command_low[15:9];
    assign v[6] = i_word.command_low[7:1];

    always_comb begin
        n_snake_active = r_snake_active;
        n_snake_head   = r_snake_head;
        n_snake_left   = r_snake_left;
        n_snake_right  = r_snake_right;
        emit           = 1'b0;
        o_job          = '0;
        unique case (i_word.operation)
            tsfsa_pkg::OP_STRIP, tsfsa_pkg::OP_FAN: begin
                o_job.mode = (i_word.operation == tsfsa_pkg::OP_FAN) ?
                             tsfsa_pkg::MODE_FAN : tsfsa_pkg::MODE_STRIP;
                o_job.idx  = v;
                emit       = !v[0][6] && !v[1][6] && !v[2][6];
                // run stops at the first index of 64 or more
                if (v[3][6]) begin
                    o_job.count = 3'd1;
                end else if (v[4][6]) begin
                    o_job.count = 3'd2;
                end else if (v[5][6]) begin
                    o_job.count = 3'd3;
                end else if (v[6][6]) begin
                    o_job.count = 3'd4;
                end else begin
                    o_job.count = 3'd5;
                end
            end
            tsfsa_pkg::OP_SNAKE_START: begin
                n_snake_head      = i_word.command_high[7:0];
                n_snake_left      = i_word.command_high[15:8];
                n_snake_right     = i_word.command_high[23:16];
                o_job.mode        = tsfsa_pkg::MODE_SNAKE;
                o_job.idx[0]      = {1'b0, i_word.command_high[6:1]};
                o_job.idx[1]      = i_word.command_high[15:9];
                o_job.idx[2]      = i_word.command_high[23:17];
                o_job.count       = 3'd1;
                o_job.snake_ended = i_word.command_high[7];
                emit              = i_word.command_high[0];
                n_snake_active    = i_word.command_high[0] && !i_word.command_high[7];
            end
            tsfsa_pkg::OP_SNAKE_BYTE: begin
                o_job.mode        = tsfsa_pkg::MODE_SNAKE;
                o_job.idx[0]      = {1'b0, i_word.snake_byte[6:1]};
                o_job.idx[1]      = i_word.snake_byte[0] ? r_snake_left[7:1]
                                                         : r_snake_head[7:1];
                o_job.idx[2]      = i_word.snake_byte[0] ? r_snake_head[7:1]
                                                         : r_snake_right[7:1];
                o_job.count       = 3'd1;
                o_job.snake_ended = i_word.snake_byte[7];
                if (r_snake_active) begin
                    emit           = 1'b1;
                    n_snake_head   = i_word.snake_byte;
                    n_snake_active = !i_word.snake_byte[7];
                    if (i_word.snake_byte[0]) begin
                        n_snake_right = r_snake_head;
                    end else begin
                        n_snake_left = r_snake_head;
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign o_job_push = i_accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snake_active <= 1'b0;
            r_snake_head   <= '0;
            r_snake_left   <= '0;
            r_snake_right  <= '0;
        end else if (i_accept) begin
            r_snake_active <= n_snake_active;
            r_snake_head   <= n_snake_head;
            r_snake_left   <= n_snake_left;
            r_snake_right  <= n_snake_right;
        end
    end

endmodule

// ===== rtl/core/tsfsa_queue.sv =====
// Short job queue between front end and back end.
`include "triangle_strip_fan_snake_assembler_macros.svh"

module tsfsa_queue #(
    parameter int DEPTH = tsfsa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tsfsa_pkg::t_job i_data,
    input  logic            i_pop,
    output tsfsa_pkg::t_job o_data,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    tsfsa_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `TSFSA_ASSERT_NOW(a_q_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_CNT)
    `TSFSA_ASSERT_NEXT(a_q_push_grows, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + 1'b1)

endmodule

// ===== rtl/core/tsfsa_back.sv =====
// Back end: walks one job a triangle per cycle into the output register while it is free or popped.
`include "triangle_strip_fan_snake_assembler_macros.svh"

module tsfsa_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  tsfsa_pkg::t_job      i_job,
    output logic                 o_job_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output tsfsa_pkg::t_out_word o_word
);

    logic [tsfsa_pkg::CNT_W-1:0] r_k;
    logic                        r_out_valid;
    tsfsa_pkg::t_out_word        r_out;

    logic [tsfsa_pkg::CNT_W-1:0] k1, k2;
    logic                        last, advance;
    tsfsa_pkg::t_out_word        tri_word;

    assign k1      = r_k + 3'd1;
    assign k2      = r_k + 3'd2;
    assign last    = (r_k == i_job.count - 3'd1);
    assign advance = i_job_valid && (!r_out_valid || i_pop);

    always_comb begin
        tri_word               = '0;
        tri_word.vertex_third  = i_job.idx[k2];
        tri_word.last_of_run   = last;
        tri_word.snake_ended   = i_job.snake_ended;
        if (i_job.mode == tsfsa_pkg::MODE_FAN) begin
            tri_word.vertex_first  = i_job.idx[0];
            tri_word.vertex_second = i_job.idx[k1];
        end else if (r_k[0]) begin
            // odd strip triangles swap winding
            tri_word.vertex_first  = i_job.idx[k1];
            tri_word.vertex_second = i_job.idx[r_k];
        end else begin
            tri_word.vertex_first  = i_job.idx[r_k];
            tri_word.vertex_second = i_job.idx[k1];
        end
    end

    assign o_job_pop = advance && last;
    assign o_empty   = !r_out_valid;
    assign o_word    = r_out;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= tri_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_k         <= last ? '0 : k1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `TSFSA_ASSERT_NOW(a_bk_k_in_run, i_clk, i_rst_n, i_job_valid, r_k < i_job.count)
    `TSFSA_ASSERT_NOW(a_bk_end_is_last, i_clk, i_rst_n, r_out_valid && r_out.snake_ended, r_out.last_of_run)

endmodule

// ===== tb/sv/triangle_strip_fan_snake_assembler_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the strip/fan/snake triangle assembler.

import tsfsa_pkg::*;

// Tracks the snake state and the queue of triangles still owed by the block.
class triangle_scoreboard;
    bit            snake_on;
    logic [7:0]    head_byte;
    logic [7:0]    left_byte;
    logic [7:0]    right_byte;
    t_out_word     owed_q[$];
    int            errors;

    function new();
        snake_on   = 1'b0;
        head_byte  = '0;
        left_byte  = '0;
        right_byte = '0;
        errors     = 0;
    endfunction

    function void owe_triangle(logic [6:0] a, logic [6:0] b, logic [6:0] c, logic ended);
        t_out_word t;
        t.vertex_first  = a;
        t.vertex_second = b;
        t.vertex_third  = c;
        t.last_of_run   = 1'b0;
        t.snake_ended   = ended;
        owed_q.push_back(t);
    endfunction

    // Snake triangle: head index, then left and right with their side bit dropped.
    function void owe_snake_triangle();
        owe_triangle({1'b0, head_byte[6:1]}, left_byte[7:1], right_byte[7:1], head_byte[7]);
        owed_q[owed_q.size()-1].last_of_run = 1'b1;
        snake_on = !head_byte[7];
    endfunction

    // Returns 0 only for a snake byte that arrives with no snake running.
    function bit note_word(t_in_word w);
        logic [6:0][6:0] v;
        int              i;
        case (w.operation)
            OP_STRIP, OP_FAN: begin
                v[0] = w.command_high[23:17];
                v[1] = w.command_high[15:9];
                v[2] = w.command_high[7:1];
                v[3] = w.command_low[31:25];
                v[4] = w.command_low[23:17];
                v[5] = w.command_low[15:9];
                v[6] = w.command_low[7:1];
                // index 64 or more has bit 6 set
                if (v[0][6] || v[1][6] || v[2][6])
                    return 1'b1;
                owe_triangle(v[0], v[1], v[2], 1'b0);
                for (i = 3; i < 7; i++) begin
                    if (v[i][6])
                        break;
                    if (w.operation == OP_FAN)
                        owe_triangle(v[0], v[i-1], v[i], 1'b0);
                    else if (i % 2)
                        owe_triangle(v[i-1], v[i-2], v[i], 1'b0);
                    else
                        owe_triangle(v[i-2], v[i-1], v[i], 1'b0);
                end
                owed_q[owed_q.size()-1].last_of_run = 1'b1;
                return 1'b1;
            end
            OP_SNAKE_START: begin
                head_byte  = w.command_high[7:0];
                left_byte  = w.command_high[15:8];
                right_byte = w.command_high[23:16];
                if (!head_byte[0])
                    snake_on = 1'b0;
                else
                    owe_snake_triangle();
                return 1'b1;
            end
            default: begin
                if (!snake_on)
                    return 1'b0;
                if (w.snake_byte[0])
                    right_byte = head_byte;
                else
                    left_byte = head_byte;
                head_byte = w.snake_byte;
                owe_snake_triangle();
                return 1'b1;
            end
        endcase
    endfunction

    function void check_triangle(t_out_word got);
        t_out_word exp;
        if (owed_q.size() == 0) begin
            $error("unexpected triangle %0d/%0d/%0d", got.vertex_first, got.vertex_second,
                   got.vertex_third);
            errors++;
            return;
        end
        exp = owed_q.pop_front();
        if (got.vertex_first !== exp.vertex_first) begin
            $error("vertex_first: expected %0d, got %0d", exp.vertex_first, got.vertex_first);
            errors++;
        end
        if (got.vertex_second !== exp.vertex_second) begin
            $error("vertex_second: expected %0d, got %0d", exp.vertex_second, got.vertex_second);
            errors++;
        end
        if (got.vertex_third !== exp.vertex_third) begin
            $error("vertex_third: expected %0d, got %0d", exp.vertex_third, got.vertex_third);
            errors++;
        end
        if (got.last_of_run !== exp.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", exp.last_of_run, got.last_of_run);
            errors++;
        end
        if (got.snake_ended !== exp.snake_ended) begin
            $error("snake_ended: expected %0d, got %0d", exp.snake_ended, got.snake_ended);
            errors++;
        end
    endfunction

    function int owed_count();
        return owed_q.size();
    endfunction
endclass

module triangle_strip_fan_snake_assembler_tb;

    localparam int WORD_TARGET = 380;
    // Worst case is roughly 380 words of up to 5 triangles each under long pop stalls, plus sender gaps;
    // this limit is many times that.
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 16;

    // Receiver pop styles, switched at random.
    typedef enum logic [1:0] {
        POP_STEADY,
        POP_MOSTLY,
        POP_HALF,
        POP_SPARSE
    } pop_style_e;

    logic      i_clk;
    logic      i_rst_n  = 1'b0;
    logic      push     = 1'b0;
    logic      pop      = 1'b0;
    t_in_word  i_in_word = '0;
    logic      full;
    logic      empty;
    t_out_word o_out_word;

    triangle_scoreboard board;
    int         counted_words = 0;
    int         burst_left    = 0;
    int         cycle_count   = 0;
    pop_style_e pop_style     = POP_STEADY;
    int         style_left    = 0;

    triangle_strip_fan_snake_assembler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("triangle_strip_fan_snake_assembler_tb: FAIL");
            $finish;
        end
    end

    // Strip/fan word: seven indices in their slots, every other bit random.
    function automatic t_in_word index_word(logic [1:0] op, logic [6:0] v0, logic [6:0] v1,
                                            logic [6:0] v2, logic [6:0] v3, logic [6:0] v4,
                                            logic [6:0] v5, logic [6:0] v6);
        t_in_word w;
        w.operation           = op;
        w.command_high        = $urandom();
        w.command_low         = $urandom();
        w.snake_byte          = 8'($urandom_range(0, 255));
        w.command_high[23:17] = v0;
        w.command_high[15:9]  = v1;
        w.command_high[7:1]   = v2;
        w.command_low[31:25]  = v3;
        w.command_low[23:17]  = v4;
        w.command_low[15:9]   = v5;
        w.command_low[7:1]    = v6;
        return w;
    endfunction

    function automatic t_in_word snake_start_word(logic [7:0] head, logic [7:0] lft,
                                                  logic [7:0] rgt);
        t_in_word w;
        w.operation          = OP_SNAKE_START;
        w.command_high       = $urandom();
        w.command_low        = $urandom();
        w.snake_byte         = 8'($urandom_range(0, 255));
        w.command_high[23:0] = {rgt, lft, head};
        return w;
    endfunction

    function automatic t_in_word snake_byte_word(logic [7:0] b);
        t_in_word w;
        w.operation    = OP_SNAKE_BYTE;
        w.command_high = $urandom();
        w.command_low  = $urandom();
        w.snake_byte   = b;
        return w;
    endfunction

    // Offer one word and hold it until taken; between bursts the sender goes quiet.
    // push is only lowered when a real gap follows, so it never toggles within a step.
    task automatic send_word(t_in_word w);
        int gap;
        i_in_word <= w;
        push      <= 1'b1;
        do @(posedge i_clk); while (full !== 1'b0);
        if (board.note_word(w))
            counted_words++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Receiver: check a triangle whenever one is taken, then pick the next pop.
    // Outputs are read in the active region of the edge, before the block's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && empty === 1'b0)
            board.check_triangle(o_out_word);
        if (style_left == 0) begin
            pop_style  = pop_style_e'($urandom_range(0, 3));
            style_left = $urandom_range(10, 80);
        end else begin
            style_left--;
        end
        case (pop_style)
            POP_STEADY: pop <= 1'b1;
            POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
            POP_HALF:   pop <= 1'($urandom_range(0, 1));
            default:    pop <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin
        logic [6:0] iv [7];
        logic [7:0] head_b;
        logic [7:0] b;
        int         cut;
        int         len;
        int         kind;
        int         k;
        int         j;

        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed words ----
        // full strip and full fan with index extremes, then an all-zero strip
        send_word(index_word(OP_STRIP, 7'd0, 7'd63, 7'd1, 7'd62, 7'd2, 7'd61, 7'd3));
        send_word(index_word(OP_FAN, 7'd63, 7'd0, 7'd62, 7'd1, 7'd61, 7'd2, 7'd60));
        send_word(index_word(OP_STRIP, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0));
        // bad leading index in each of the first three slots: nothing comes out
        send_word(index_word(OP_FAN, 7'd64, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6));
        send_word(index_word(OP_STRIP, 7'd1, 7'd127, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6));
        send_word(index_word(OP_FAN, 7'd1, 7'd2, 7'd100, 7'd3, 7'd4, 7'd5, 7'd6));
        // runs cut short by a later bad index
        send_word(index_word(OP_STRIP, 7'd5, 7'd6, 7'd7, 7'd64, 7'd8, 7'd9, 7'd10));
        send_word(index_word(OP_STRIP, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd127, 7'd10));
        send_word(index_word(OP_FAN, 7'd9, 7'd8, 7'd7, 7'd6, 7'd5, 7'd4, 7'd70));
        send_word(index_word(OP_FAN, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127));
        // snake byte with no snake running is dropped
        send_word(snake_byte_word(8'h37));
        // start with head bit 0 clear: loads but stays inactive
        send_word(snake_start_word(8'h10, 8'h22, 8'h44));
        send_word(snake_byte_word(8'h05));
        // proper snake: left side, right side, a strip in the middle, restart, end
        send_word(snake_start_word(8'h7F, 8'hFF, 8'h00));
        send_word(snake_byte_word(8'h7E));
        send_word(snake_byte_word(8'h01));
        send_word(index_word(OP_STRIP, 7'd10, 7'd11, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16));
        send_word(snake_byte_word(8'h42));
        send_word(snake_start_word(8'h03, 8'h80, 8'hFE));
        send_word(snake_byte_word(8'hFF));
        send_word(snake_byte_word(8'h00));
        // start whose head already carries the end bit
        send_word(snake_start_word(8'h81, 8'h12, 8'h34));
        send_word(snake_byte_word(8'h02));

        // ---- random words ----
        while (counted_words < WORD_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                // strip/fan whose first bad index lands at a random slot (7 = none)
                cut = $urandom_range(0, 9);
                if (cut > 7)
                    cut = 7;
                for (k = 0; k < 7; k++) begin
                    if (k < cut)
                        iv[k] = 7'($urandom_range(0, 63));
                    else if (k == cut)
                        iv[k] = 7'($urandom_range(64, 127));
                    else
                        iv[k] = 7'($urandom_range(0, 127));
                end
                send_word(index_word($urandom_range(0, 1) ? OP_FAN : OP_STRIP, iv[0], iv[1],
                                     iv[2], iv[3], iv[4], iv[5], iv[6]));
            end else if (kind <= 6) begin
                // well-formed snake with random content, sometimes interrupted
                head_b    = 8'($urandom_range(0, 255));
                head_b[0] = ($urandom_range(0, 7) != 0);
                head_b[7] = ($urandom_range(0, 7) == 0);
                send_word(snake_start_word(head_b, 8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255))));
                len = $urandom_range(1, 10);
                for (j = 0; j < len; j++) begin
                    if ($urandom_range(0, 5) == 0)
                        send_word(index_word($urandom_range(0, 1) ? OP_FAN : OP_STRIP,
                                             7'($urandom_range(0, 63)),
                                             7'($urandom_range(0, 63)),
                                             7'($urandom_range(0, 63)),
                                             7'($urandom_range(0, 127)),
                                             7'($urandom_range(0, 127)),
                                             7'($urandom_range(0, 127)),
                                             7'($urandom_range(0, 127))));
                    b    = 8'($urandom_range(0, 255));
                    b[7] = (j == len - 1) && $urandom_range(0, 1);
                    send_word(snake_byte_word(b));
                end
            end else if (kind == 7) begin
                // pure noise
                send_word(index_word(2'($urandom_range(0, 3)),
                                     7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                     7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                     7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                     7'($urandom_range(0, 127))));
            end else if (kind == 8) begin
                // stray snake byte, often with no snake running
                send_word(snake_byte_word(8'($urandom_range(0, 255))));
            end else begin
                // restart in the middle of whatever is running
                send_word(snake_start_word(8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255))));
            end
        end
        push <= 1'b0;

        // drain, then give stray triangles a chance to show up
        while (board.owed_count() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (board.errors == 0)
            $display("triangle_strip_fan_snake_assembler_tb: PASS");
        else
            $display("triangle_strip_fan_snake_assembler_tb: FAIL");
        $finish;
    end

endmodule
